[rtl/dtds_pkg.sv]
package dtds_pkg;

   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int HOUR_W  = 5;
   localparam int MIN_W   = 6;
   localparam int SEC_W   = 6;

   // quotient of year by 100, and the product used to find it
   localparam int QY_W     = 8;
   localparam int RECIP_W  = 13;
   localparam int PROD_W   = YEAR_W + RECIP_W;
   localparam int RECIP_SH = 19;
   localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

   localparam int MOFF_W = 9;
   localparam int TOD_W  = 17;
   localparam int DAYS_W = 23;
   localparam int DIFF_W = 40;

   localparam logic [DAYS_W-1:0] DAYS_PER_YEAR = 23'd365;
   localparam logic [TOD_W-1:0]  SECS_PER_DAY  = 17'd86400;
   localparam logic [TOD_W-1:0]  SECS_PER_HOUR = 17'd3600;
   localparam logic [TOD_W-1:0]  SECS_PER_MIN  = 17'd60;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
   localparam logic [HOUR_W-1:0]  HOUR_MAX  = 5'd23;
   localparam logic [MIN_W-1:0]   MIN_MAX   = 6'd59;
   localparam logic [SEC_W-1:0]   SEC_MAX   = 6'd59;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [HOUR_W-1:0]  hour;
      logic [MIN_W-1:0]   minute;
      logic [SEC_W-1:0]   second;
   } dtds_date_type;

   // per-stage load enables shared by the lanes and the merge stage
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } dtds_adv_type;

   // days before the first of a month in a common year
   function automatic logic [MOFF_W-1:0] month_start(input logic [MONTH_W-1:0] month);
      logic [MOFF_W-1:0] off;
      case (month)
         4'd2:    off = 9'd31;
         4'd3:    off = 9'd59;
         4'd4:    off = 9'd90;
         4'd5:    off = 9'd120;
         4'd6:    off = 9'd151;
         4'd7:    off = 9'd181;
         4'd8:    off = 9'd212;
         4'd9:    off = 9'd243;
         4'd10:   off = 9'd273;
         4'd11:   off = 9'd304;
         4'd12:   off = 9'd334;
         default: off = 9'd0;
      endcase
      return off;
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      case (month)
         4'd2:    len = leap ? 5'd29 : 5'd28;
         4'd4,
         4'd6,
         4'd9,
         4'd11:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

[rtl/dtds_if.sv]
interface dtds_req_if
   import dtds_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [YEAR_W-1:0]  first_year;
   logic [MONTH_W-1:0] first_month;
   logic [DAY_W-1:0]   first_day;
   logic [HOUR_W-1:0]  first_hour;
   logic [MIN_W-1:0]   first_minute;
   logic [SEC_W-1:0]   first_second;
   logic [YEAR_W-1:0]  second_year;
   logic [MONTH_W-1:0] second_month;
   logic [DAY_W-1:0]   second_day;
   logic [HOUR_W-1:0]  second_hour;
   logic [MIN_W-1:0]   second_minute;
   logic [SEC_W-1:0]   second_second;

   modport source (
      output valid, first_year, first_month, first_day, first_hour, first_minute,
             first_second, second_year, second_month, second_day, second_hour,
             second_minute, second_second,
      input  ready
   );
   modport sink (
      input  valid, first_year, first_month, first_day, first_hour, first_minute,
             first_second, second_year, second_month, second_day, second_hour,
             second_minute, second_second,
      output ready
   );
endinterface

interface dtds_rsp_if
   import dtds_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic                     first_valid;
   logic                     second_valid;
   logic signed [DIFF_W-1:0] diff_seconds;

   modport source (output valid, first_valid, second_valid, diff_seconds, input ready);
   modport sink (input valid, first_valid, second_valid, diff_seconds, output ready);
endinterface

[rtl/dtds_lane.sv]
module dtds_lane
   import dtds_pkg::*;
#(
   parameter int MAX_YEAR = 9999
) (
   input  logic                clock,
   input  dtds_adv_type        adv,
   input  dtds_date_type       date_in,
   output logic                ok,
   output logic [DIFF_W-1:0]   secs
);

   // stage 1 registers
   dtds_date_type       date1_ff;
   logic [QY_W-1:0]     qy1_ff;
   logic [PROD_W-1:0]   prod;

   // stage 2 registers
   logic                ok2_ff,   ok2_in;
   logic [YEAR_W-1:0]   p2_ff,    p2_in;
   logic [QY_W-1:0]     qp2_ff,   qp2_in;
   logic                ladj2_ff, ladj2_in;
   logic [MOFF_W-1:0]   moff2_ff, moff2_in;
   logic [DAY_W-1:0]    dm2_ff,   dm2_in;
   logic [TOD_W-1:0]    tod2_ff,  tod2_in;

   // stage 3 registers
   logic                ok3_ff;
   logic [DAYS_W-1:0]   days3_ff, days3_in;
   logic [TOD_W-1:0]    tod3_ff;

   // stage 4 registers
   logic                ok4_ff;
   logic [DIFF_W-1:0]   secs4_ff, secs4_in;

   logic [YEAR_W-1:0]   ry;
   logic                r_zero;
   logic                leap;
   logic                year_ok, month_ok, day_ok, time_ok;

   // divide year by 100 with a scaled reciprocal
   assign prod = PROD_W'(date_in.year) * PROD_W'(RECIP_100);

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         date1_ff <= date_in;
         qy1_ff   <= prod[RECIP_SH +: QY_W];
      end
   end

   // leap rule, validity, and pieces of the day count
   always_comb begin
      ry       = date1_ff.year - (YEAR_W'(qy1_ff) * YEAR_W'(100));
      r_zero   = (ry == '0);
      leap     = ((date1_ff.year[1:0] == 2'd0) && !r_zero) ||
                 (r_zero && (qy1_ff[1:0] == 2'd0));
      year_ok  = (date1_ff.year != '0) && (32'(date1_ff.year) <= MAX_YEAR);
      month_ok = (date1_ff.month >= MONTH_JAN) && (date1_ff.month <= MONTH_DEC);
      day_ok   = (date1_ff.day != '0) &&
                 (date1_ff.day <= month_len(date1_ff.month, leap));
      time_ok  = (date1_ff.hour <= HOUR_MAX) && (date1_ff.minute <= MIN_MAX) &&
                 (date1_ff.second <= SEC_MAX);
      ok2_in   = year_ok && month_ok && day_ok && time_ok;
      p2_in    = date1_ff.year - YEAR_W'(1);
      qp2_in   = qy1_ff - QY_W'(r_zero);
      ladj2_in = leap && (date1_ff.month > MONTH_FEB);
      moff2_in = month_start(date1_ff.month);
      dm2_in   = date1_ff.day - DAY_W'(1);
      tod2_in  = (TOD_W'(date1_ff.hour) * SECS_PER_HOUR) +
                 (TOD_W'(date1_ff.minute) * SECS_PER_MIN) + TOD_W'(date1_ff.second);
   end

   always_ff @(posedge clock) begin
      if (adv.s2) begin
         ok2_ff   <= ok2_in;
         p2_ff    <= p2_in;
         qp2_ff   <= qp2_in;
         ladj2_ff <= ladj2_in;
         moff2_ff <= moff2_in;
         dm2_ff   <= dm2_in;
         tod2_ff  <= tod2_in;
      end
   end

   // sum days of whole years, whole months and the current month
   assign days3_in = (DAYS_W'(p2_ff) * DAYS_PER_YEAR) + DAYS_W'(p2_ff >> 2)
                   - DAYS_W'(qp2_ff) + DAYS_W'(qp2_ff >> 2) + DAYS_W'(moff2_ff)
                   + DAYS_W'(ladj2_ff) + DAYS_W'(dm2_ff);

   always_ff @(posedge clock) begin
      if (adv.s3) begin
         ok3_ff   <= ok2_ff;
         days3_ff <= days3_in;
         tod3_ff  <= tod2_ff;
      end
   end

   // scale days to seconds and add time of day
   assign secs4_in = (DIFF_W'(days3_ff) * DIFF_W'(SECS_PER_DAY)) + DIFF_W'(tod3_ff);

   always_ff @(posedge clock) begin
      if (adv.s4) begin
         ok4_ff   <= ok3_ff;
         secs4_ff <= secs4_in;
      end
   end

   assign ok   = ok4_ff;
   assign secs = secs4_ff;

endmodule

[rtl/dtds_merge.sv]
module dtds_merge
   import dtds_pkg::*;
(
   input  logic                     clock,
   input  logic                     load,
   input  logic                     first_ok,
   input  logic [DIFF_W-1:0]        first_secs,
   input  logic                     second_ok,
   input  logic [DIFF_W-1:0]        second_secs,
   output logic                     first_valid,
   output logic                     second_valid,
   output logic signed [DIFF_W-1:0] diff_seconds
);

   logic                first_ff;
   logic                second_ff;
   logic [DIFF_W-1:0]   diff_ff, diff_in;

   // subtract lane results, drop to zero unless both dates hold
   assign diff_in = (first_ok && second_ok) ? (first_secs - second_secs) : '0;

   always_ff @(posedge clock) begin
      if (load) begin
         first_ff  <= first_ok;
         second_ff <= second_ok;
         diff_ff   <= diff_in;
      end
   end

   assign first_valid  = first_ff;
   assign second_valid = second_ff;
   assign diff_seconds = signed'(diff_ff);

endmodule

[rtl/date_time_difference_seconds_core.sv]
// Date-time difference in seconds.
//
// A request on req_chan carries two Gregorian date-times. Each goes to its
// own conversion lane, which checks it and counts seconds since the start
// of year 1; a merge stage subtracts the two counts. The response on
// rsp_chan carries both validity flags and the signed difference, first
// minus second, which is zero when either date-time is invalid.
//
// rsp_chan.valid rises once a request has passed five register stages:
// lane stages 1 to 4 and the merge stage. One request is taken every cycle
// unless a stalled response fills the pipe; the year divide by reciprocal,
// the day sum and the day-to-second multiply each have a stage of their own.
// When the receiver holds rsp_chan.ready low the result stays in the output
// register and the stages behind it keep filling until each holds a
// request, then req_chan.ready drops.
// Reset (synchronous, active high) clears the stage valid bits; no result
// is pending afterward.
module date_time_difference_seconds_core
   import dtds_pkg::*;
#(
   parameter int MAX_YEAR = 9999
) (
   input  logic          clock,
   input  logic          reset,
   dtds_req_if.sink      req_chan,
   dtds_rsp_if.source    rsp_chan
);

   localparam int STAGES = 5;

   logic [STAGES:1]   valid_ff, valid_in;
   logic [STAGES:1]   load;
   dtds_adv_type      adv;
   dtds_date_type     first_date, second_date;
   logic              first_ok, second_ok;
   logic [DIFF_W-1:0] first_secs, second_secs;

   // advance a stage when it is empty or its successor advances
   always_comb begin
      load[STAGES] = !valid_ff[STAGES] || rsp_chan.ready;
      for (int k = STAGES - 1; k >= 1; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
      valid_in[1] = load[1] ? req_chan.valid : valid_ff[1];
      for (int k = 2; k <= STAGES; k++) begin
         valid_in[k] = load[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign adv = '{s1: load[1], s2: load[2], s3: load[3], s4: load[4], s5: load[5]};

   assign req_chan.ready = load[1];
   assign rsp_chan.valid = valid_ff[STAGES];

   assign first_date  = '{year: req_chan.first_year, month: req_chan.first_month,
                          day: req_chan.first_day, hour: req_chan.first_hour,
                          minute: req_chan.first_minute, second: req_chan.first_second};
   assign second_date = '{year: req_chan.second_year, month: req_chan.second_month,
                          day: req_chan.second_day, hour: req_chan.second_hour,
                          minute: req_chan.second_minute, second: req_chan.second_second};

   dtds_lane #(.MAX_YEAR(MAX_YEAR)) u_lane_first (
      .clock   (clock),
      .adv     (adv),
      .date_in (first_date),
      .ok      (first_ok),
      .secs    (first_secs)
   );

   dtds_lane #(.MAX_YEAR(MAX_YEAR)) u_lane_second (
      .clock   (clock),
      .adv     (adv),
      .date_in (second_date),
      .ok      (second_ok),
      .secs    (second_secs)
   );

   dtds_merge u_merge (
      .clock        (clock),
      .load         (adv.s5),
      .first_ok     (first_ok),
      .first_secs   (first_secs),
      .second_ok    (second_ok),
      .second_secs  (second_secs),
      .first_valid  (rsp_chan.first_valid),
      .second_valid (rsp_chan.second_valid),
      .diff_seconds (rsp_chan.diff_seconds)
   );

endmodule

[sim/date_time_difference_seconds_checker.sv]
module date_time_difference_seconds_checker
   import dtds_pkg::*;
#(
   parameter int MAX_YEAR = 9999
) (
   input  logic        clock,
   input  logic        reset,
   dtds_req_if         req_chan,
   dtds_rsp_if         rsp_chan,
   output int unsigned mismatch_count,
   output int unsigned pending_count
);

   typedef struct packed {
      logic                     first_valid;
      logic                     second_valid;
      logic signed [DIFF_W-1:0] diff_seconds;
   } diff_result_type;

   // predicted responses, oldest first
   diff_result_type pending_diffs[$];

   function automatic bit year_is_leap(input int unsigned year);
      return ((year % 4) == 0 && (year % 100) != 0) || ((year % 400) == 0);
   endfunction

   function automatic int unsigned month_days(input int unsigned month,
                                              input int unsigned year);
      case (month)
         MONTH_FEB:     return year_is_leap(year) ? 29 : 28;
         4, 6, 9, 11:   return 30;
         default:       return 31;
      endcase
   endfunction

   function automatic bit date_is_valid(input dtds_date_type d);
      if (d.year < 1 || d.year > MAX_YEAR)
         return 1'b0;
      if (d.month < MONTH_JAN || d.month > MONTH_DEC)
         return 1'b0;
      if (d.day < 1 || d.day > month_days(d.month, d.year))
         return 1'b0;
      if (d.hour > HOUR_MAX || d.minute > MIN_MAX || d.second > SEC_MAX)
         return 1'b0;
      return 1'b1;
   endfunction

   // seconds since 0001-01-01 00:00:00 for a valid date-time
   function automatic longint seconds_since_epoch(input dtds_date_type d);
      longint past_years;
      longint days;
      past_years = longint'(d.year) - 1;
      days = 365 * past_years + past_years / 4 - past_years / 100 + past_years / 400;
      // walk the months already finished this year, leap day included
      for (int unsigned m = 1; m < d.month; m++)
         days += month_days(m, d.year);
      days += longint'(d.day) - 1;
      return days * longint'(SECS_PER_DAY) + longint'(d.hour) * longint'(SECS_PER_HOUR)
             + longint'(d.minute) * longint'(SECS_PER_MIN) + longint'(d.second);
   endfunction

   function automatic diff_result_type predict_difference(input dtds_date_type a,
                                                          input dtds_date_type b);
      diff_result_type r;
      longint delta;
      r.first_valid  = date_is_valid(a);
      r.second_valid = date_is_valid(b);
      r.diff_seconds = '0;
      if (r.first_valid && r.second_valid) begin
         delta = seconds_since_epoch(a) - seconds_since_epoch(b);
         r.diff_seconds = delta[DIFF_W-1:0];
      end
      return r;
   endfunction

   task automatic note_mismatch(input string what, input diff_result_type want,
                                input diff_result_type got, input bit has_want);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         if (has_want)
            $display("%0t: %s: expected valid %0d/%0d diff %0d, got valid %0d/%0d diff %0d",
                     $time, what, want.first_valid, want.second_valid, want.diff_seconds,
                     got.first_valid, got.second_valid, got.diff_seconds);
         else
            $display("%0t: %s: got valid %0d/%0d diff %0d", $time, what,
                     got.first_valid, got.second_valid, got.diff_seconds);
      end
   endtask

   always @(posedge clock) begin : track_differences
      dtds_date_type   a;
      dtds_date_type   b;
      diff_result_type want;
      diff_result_type got;
      if (reset) begin
         pending_diffs.delete();
         mismatch_count = 0;
         pending_count <= 0;
      end else begin
         // predict each accepted request
         if (req_chan.valid && req_chan.ready) begin
            a.year   = req_chan.first_year;
            a.month  = req_chan.first_month;
            a.day    = req_chan.first_day;
            a.hour   = req_chan.first_hour;
            a.minute = req_chan.first_minute;
            a.second = req_chan.first_second;
            b.year   = req_chan.second_year;
            b.month  = req_chan.second_month;
            b.day    = req_chan.second_day;
            b.hour   = req_chan.second_hour;
            b.minute = req_chan.second_minute;
            b.second = req_chan.second_second;
            pending_diffs.push_back(predict_difference(a, b));
         end
         // compare each accepted response with the oldest prediction
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.first_valid  = rsp_chan.first_valid;
            got.second_valid = rsp_chan.second_valid;
            got.diff_seconds = rsp_chan.diff_seconds;
            if (pending_diffs.size() == 0) begin
               want = '0;
               note_mismatch("unexpected response", want, got, 1'b0);
            end else begin
               want = pending_diffs.pop_front();
               if (got.first_valid !== want.first_valid ||
                   got.second_valid !== want.second_valid ||
                   got.diff_seconds !== want.diff_seconds)
                  note_mismatch("response mismatch", want, got, 1'b1);
            end
         end
         pending_count <= pending_diffs.size();
      end
   end

endmodule

[sim/date_time_difference_seconds_core_test.sv]
module date_time_difference_seconds_core_test;
   import dtds_pkg::*;

   logic        clock;
   logic        reset;
   int unsigned mismatch_count;
   int unsigned pending_count;
   int unsigned sent_count;
   int unsigned taken_count;
   bit          req_calm;
   bit          rsp_calm;

   dtds_req_if req_chan ();
   dtds_rsp_if rsp_chan ();

   date_time_difference_seconds_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   date_time_difference_seconds_checker scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic dtds_date_type date_of(input logic [YEAR_W-1:0]  year,
                                             input logic [MONTH_W-1:0] month,
                                             input logic [DAY_W-1:0]   day,
                                             input logic [HOUR_W-1:0]  hour,
                                             input logic [MIN_W-1:0]   minute,
                                             input logic [SEC_W-1:0]   second);
      dtds_date_type d;
      d.year   = year;
      d.month  = month;
      d.day    = day;
      d.hour   = hour;
      d.minute = minute;
      d.second = second;
      return d;
   endfunction

   // mostly in range; days past 28 land on either side of the month end
   function automatic dtds_date_type random_valid_date();
      dtds_date_type d;
      case ($urandom_range(0, 5))
         0:       d.year = YEAR_W'(100 * $urandom_range(1, 99));
         1:       d.year = YEAR_W'($urandom_range(1, 8));
         2:       d.year = YEAR_W'($urandom_range(9992, 9999));
         default: d.year = YEAR_W'($urandom_range(1, 9999));
      endcase
      d.month  = MONTH_W'($urandom_range(1, 12));
      d.day    = ($urandom_range(0, 3) == 0) ? DAY_W'($urandom_range(29, 31))
                                             : DAY_W'($urandom_range(1, 28));
      d.hour   = HOUR_W'($urandom_range(0, 23));
      d.minute = MIN_W'($urandom_range(0, 59));
      d.second = SEC_W'($urandom_range(0, 59));
      return d;
   endfunction

   // push one field out of range
   function automatic dtds_date_type broken_date(input dtds_date_type d);
      case ($urandom_range(0, 5))
         0: d.year   = ($urandom_range(0, 1) == 0) ? '0 : YEAR_W'($urandom_range(10000, 16383));
         1: d.month  = ($urandom_range(0, 1) == 0) ? '0 : MONTH_W'($urandom_range(13, 15));
         2: d.day    = '0;
         3: d.hour   = HOUR_W'($urandom_range(24, 31));
         4: d.minute = MIN_W'($urandom_range(60, 63));
         default: d.second = SEC_W'($urandom_range(60, 63));
      endcase
      return d;
   endfunction

   function automatic dtds_date_type raw_date();
      return date_of(YEAR_W'($urandom_range(0, 16383)), MONTH_W'($urandom_range(0, 15)),
                     DAY_W'($urandom_range(0, 31)), HOUR_W'($urandom_range(0, 31)),
                     MIN_W'($urandom_range(0, 63)), SEC_W'($urandom_range(0, 63)));
   endfunction

   task automatic send_request(input dtds_date_type a, input dtds_date_type b);
      int unsigned gap;
      gap = req_calm ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.first_year    <= a.year;
      req_chan.first_month   <= a.month;
      req_chan.first_day     <= a.day;
      req_chan.first_hour    <= a.hour;
      req_chan.first_minute  <= a.minute;
      req_chan.first_second  <= a.second;
      req_chan.second_year   <= b.year;
      req_chan.second_month  <= b.month;
      req_chan.second_day    <= b.day;
      req_chan.second_hour   <= b.hour;
      req_chan.second_minute <= b.minute;
      req_chan.second_second <= b.second;
      req_chan.valid         <= 1'b1;
      // hold until the request is taken
      do @(posedge clock); while (!req_chan.ready);
      sent_count++;
      if (sent_count % 40 == 0)
         req_calm = ($urandom_range(0, 3) == 0);
   endtask

   // response side: stall a random number of cycles before each response
   initial begin : drain_responses
      int unsigned stall;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = rsp_calm ? 0 : $urandom_range(0, 14);
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         taken_count++;
         if (taken_count % 40 == 0)
            rsp_calm = ($urandom_range(0, 3) == 0);
      end
   end

   initial begin : run_requests
      dtds_date_type a;
      dtds_date_type b;
      dtds_date_type epoch;
      dtds_date_type last_second;
      reset                  <= 1'b1;
      req_chan.valid         <= 1'b0;
      req_chan.first_year    <= '0;
      req_chan.first_month   <= '0;
      req_chan.first_day     <= '0;
      req_chan.first_hour    <= '0;
      req_chan.first_minute  <= '0;
      req_chan.first_second  <= '0;
      req_chan.second_year   <= '0;
      req_chan.second_month  <= '0;
      req_chan.second_day    <= '0;
      req_chan.second_hour   <= '0;
      req_chan.second_minute <= '0;
      req_chan.second_second <= '0;
      sent_count  = 0;
      taken_count = 0;
      req_calm    = 1'b0;
      rsp_calm    = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: range ends, invalid fields, leap rules
      epoch       = date_of(1, 1, 1, 0, 0, 0);
      last_second = date_of(9999, 12, 31, 23, 59, 59);
      send_request(epoch, epoch);
      send_request(last_second, epoch);
      send_request(epoch, last_second);
      send_request(last_second, date_of(9999, 12, 31, 23, 59, 58));
      send_request(date_of(0, 1, 1, 0, 0, 0), epoch);
      send_request(epoch, date_of(10000, 1, 1, 0, 0, 0));
      send_request(date_of(16383, 15, 31, 31, 63, 63), date_of(0, 0, 0, 0, 0, 0));
      send_request(date_of(2023, 13, 1, 0, 0, 0), epoch);
      send_request(date_of(2023, 5, 0, 0, 0, 0), epoch);
      send_request(date_of(2023, 4, 31, 0, 0, 0), date_of(2023, 4, 30, 0, 0, 0));
      send_request(date_of(2023, 4, 30, 0, 0, 0), date_of(2023, 1, 31, 0, 0, 0));
      send_request(date_of(2000, 2, 29, 12, 0, 0), date_of(1999, 12, 31, 0, 0, 0));
      send_request(date_of(1900, 2, 29, 0, 0, 0), date_of(1900, 2, 28, 0, 0, 0));
      send_request(date_of(2024, 2, 29, 0, 0, 0), date_of(2023, 2, 29, 0, 0, 0));
      send_request(date_of(2024, 3, 1, 0, 0, 0), date_of(2024, 2, 28, 23, 59, 59));
      send_request(date_of(2023, 3, 1, 0, 0, 0), date_of(2023, 2, 28, 23, 59, 59));
      send_request(date_of(400, 12, 31, 23, 59, 59), date_of(401, 1, 1, 0, 0, 0));
      send_request(date_of(2023, 6, 15, 24, 0, 0), epoch);
      send_request(epoch, date_of(2023, 6, 15, 0, 60, 0));
      send_request(epoch, date_of(2023, 6, 15, 0, 0, 60));
      send_request(date_of(2023, 6, 15, 23, 59, 59), date_of(2023, 6, 15, 0, 0, 0));

      // random: mostly valid pairs, some with broken or raw fields
      repeat (1300) begin
         a = random_valid_date();
         b = random_valid_date();
         case ($urandom_range(0, 15))
            0, 1: begin
               b = a;
               b.second = SEC_W'($urandom_range(0, 59));
               b.minute = MIN_W'($urandom_range(0, 59));
            end
            10:      a = broken_date(a);
            11:      b = broken_date(b);
            12: begin
               a = broken_date(a);
               b = broken_date(b);
            end
            13:      a = raw_date();
            14:      b = raw_date();
            15: begin
               a = raw_date();
               b = raw_date();
            end
            default: ;
         endcase
         send_request(a, b);
      end
      req_chan.valid <= 1'b0;

      // drain, then allow the pipe latency for stray responses
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("date_time_difference_seconds_core regression: pass");
      else
         $display("date_time_difference_seconds_core regression: fail");
      $finish;
   end

   initial begin : watchdog
      #3000000;
      $display("date_time_difference_seconds_core regression: fail");
      $finish;
   end

endmodule
